[src/spe_pkg.sv]
package spe_pkg;

  // Widths of the configuration registers and of the port
  localparam int unsigned WIDTH_W    = 11;
  localparam int unsigned HEIGHT_W   = 12;
  localparam int unsigned THRESH_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned PIX_W      = 8;

  localparam int unsigned MAX_WIDTH_DEF = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_KERNEL_MODE  = 2'd2,
    REG_THRESHOLD    = 2'd3
  } cfg_reg_t;

  localparam logic OPC_PIXEL = 1'b0;
  localparam logic OPC_FLUSH = 1'b1;

  localparam logic KERNEL_SOBEL   = 1'b0;
  localparam logic KERNEL_PREWITT = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [THRESH_W-1:0] THRESH_RST = 8'd127;

  // floor(x/3) for x <= 765 as (x * 683) >> 11
  localparam logic [9:0] GRAY_MUL   = 10'd683;
  localparam int unsigned GRAY_SHIFT = 11;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic opcode;
    pix_t red;
    pix_t green;
    pix_t blue;
  } in_item_t;

  typedef struct packed {
    logic edge_res;
    logic end_of_frame;
  } out_item_t;

endpackage

[src/spe_line_mem.sv]
module spe_line_mem #(
  parameter int unsigned DEPTH = spe_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  spe_pkg::pix_t            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output spe_pkg::pix_t            rdata_a,
  output spe_pkg::pix_t            rdata_b
);

  spe_pkg::pix_t mem [DEPTH];
  spe_pkg::pix_t rdata_a_r;
  spe_pkg::pix_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first: a read of the location being written returns the new data
  always_ff @(posedge clk) begin
    rdata_a_r <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
    rdata_b_r <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

[src/spe_grad.sv]
module spe_grad (
  input  spe_pkg::win_t win,
  input  logic          kernel_mode,
  input  logic [15:0]   thr_sq,
  output logic          is_edge
);

  logic [9:0]         gx_pos;
  logic [9:0]         gx_neg;
  logic [9:0]         gy_pos;
  logic [9:0]         gy_neg;
  logic signed [11:0] gx;
  logic signed [11:0] gy;
  logic signed [23:0] sq_x;
  logic signed [23:0] sq_y;
  logic [21:0]        mag;

  function automatic logic [9:0] centre(input spe_pkg::pix_t p, input logic mode);
    centre = (mode == spe_pkg::KERNEL_PREWITT) ? {2'b00, p} : {1'b0, p, 1'b0};
  endfunction

  assign gx_pos = {2'b00, win[2]} + centre(win[5], kernel_mode) + {2'b00, win[8]};
  assign gx_neg = {2'b00, win[0]} + centre(win[3], kernel_mode) + {2'b00, win[6]};
  assign gy_pos = {2'b00, win[0]} + centre(win[1], kernel_mode) + {2'b00, win[2]};
  assign gy_neg = {2'b00, win[6]} + centre(win[7], kernel_mode) + {2'b00, win[8]};

  assign gx = $signed({2'b00, gx_pos}) - $signed({2'b00, gx_neg});
  assign gy = $signed({2'b00, gy_pos}) - $signed({2'b00, gy_neg});

  assign sq_x = gx * gx;
  assign sq_y = gy * gy;

  // each square is at most 1020^2, so 21 bits hold it
  assign mag = {1'b0, sq_x[20:0]} + {1'b0, sq_y[20:0]};

  assign is_edge = (mag >= {6'd0, thr_sq});

endmodule

[src/sobel_prewitt_edge_binarize.sv]
// Throughput: one transaction per clock cycle on the input, pixel or flush, while the
// output does not stall. An accepted transaction lands in the input register, and its
// result (if any) is then registered in the output register; results trail the pixel
// stream by W+1 pixels. Each line store takes a write and two reads in the same cycle.
// Reset (rst_n low, synchronous): counters, window, configuration and valid flags to
// defaults; the line stores and the data registers are not cleared.
module sobel_prewitt_edge_binarize #(
  parameter int unsigned MAX_WIDTH = spe_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  spe_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output spe_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spe_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (COL_W + 1 > spe_pkg::WIDTH_W) ? COL_W + 1 : spe_pkg::WIDTH_W;
  localparam int unsigned HW = spe_pkg::HEIGHT_W;

  // configuration
  logic [spe_pkg::WIDTH_W-1:0]  img_w_r;
  logic [HW-1:0]                img_h_r;
  logic                         mode_r;
  logic [spe_pkg::THRESH_W-1:0] thr_r;
  logic [15:0]                  thr_sq;
  logic [WW-1:0]                w_eff;
  logic [HW-1:0]                h_eff;
  logic                         cfg_we;
  logic                         geom_we;

  // input register
  logic          in_vld_r;
  logic          in_opc_r;
  spe_pkg::pix_t in_gray_r;
  logic [19:0]   gray_prod;
  logic [9:0]    rgb_sum;
  logic          in_acc;

  // stream state
  logic [COL_W-1:0] ic_r, ic_nxt;
  logic [COL_W-1:0] oc_r, oc_nxt;
  logic [HW-1:0]    orow_r, orow_nxt;
  logic [WW-1:0]    owed_r, owed_nxt;
  spe_pkg::win_t    win_r, win_nxt, win_shift, win_eval;

  // processing
  logic          fire;
  logic          is_pix;
  logic          emit;
  logic          interior;
  logic          oc_last;
  logic          orow_last;
  logic [WW-1:0] ic_inc;
  logic [WW-1:0] owed_inc;
  spe_pkg::pix_t border_g;
  logic          grad_edge;
  logic          edge_bit;

  spe_pkg::pix_t up_a, up_b, lo_a, lo_b;

  // output register
  logic               out_vld_r;
  spe_pkg::out_item_t out_data_r;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign geom_we   = cfg_we && ((cfg_index == spe_pkg::REG_IMAGE_WIDTH) ||
                                (cfg_index == spe_pkg::REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= spe_pkg::WIDTH_RST;
      img_h_r <= spe_pkg::HEIGHT_RST;
      mode_r  <= spe_pkg::KERNEL_SOBEL;
      thr_r   <= spe_pkg::THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        spe_pkg::REG_IMAGE_WIDTH:  img_w_r <= cfg_data[spe_pkg::WIDTH_W-1:0];
        spe_pkg::REG_IMAGE_HEIGHT: img_h_r <= cfg_data[HW-1:0];
        spe_pkg::REG_KERNEL_MODE:  mode_r  <= cfg_data[0];
        spe_pkg::REG_THRESHOLD:    thr_r   <= cfg_data[spe_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // derived geometry and threshold, straight off the register outputs
  always_comb begin
    w_eff = WW'(img_w_r);
    if (w_eff < WW'(3)) begin
      w_eff = WW'(3);
    end else if (w_eff > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end
  end

  assign h_eff  = (img_h_r < HW'(3)) ? HW'(3) : img_h_r;
  assign thr_sq = {8'd0, thr_r} * {8'd0, thr_r};

  // ---------------- input register ----------------
  assign rgb_sum   = {2'b00, in_data.red} + {2'b00, in_data.green} + {2'b00, in_data.blue};
  assign gray_prod = {10'd0, rgb_sum} * {10'd0, spe_pkg::GRAY_MUL};

  assign fire     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_opc_r  <= in_data.opcode;
      in_gray_r <= gray_prod[spe_pkg::GRAY_SHIFT +: spe_pkg::PIX_W];
    end
  end

  // ---------------- line stores ----------------
  assign is_pix = (in_opc_r == spe_pkg::OPC_PIXEL);

  spe_line_mem #(.DEPTH(MAX_WIDTH)) u_upper (
    .clk     (clk),
    .we      (fire && is_pix),
    .waddr   (ic_r),
    .wdata   (lo_a),
    .raddr_a (ic_nxt),
    .raddr_b (oc_nxt),
    .rdata_a (up_a),
    .rdata_b (up_b)
  );

  spe_line_mem #(.DEPTH(MAX_WIDTH)) u_lower (
    .clk     (clk),
    .we      (fire && is_pix),
    .waddr   (ic_r),
    .wdata   (in_gray_r),
    .raddr_a (ic_nxt),
    .raddr_b (oc_nxt),
    .rdata_a (lo_a),
    .rdata_b (lo_b)
  );

  // ---------------- window and decision ----------------
  always_comb begin
    win_shift    = win_r;
    win_shift[0] = win_r[1];
    win_shift[1] = win_r[2];
    win_shift[2] = up_a;
    win_shift[3] = win_r[4];
    win_shift[4] = win_r[5];
    win_shift[5] = lo_a;
    win_shift[6] = win_r[7];
    win_shift[7] = win_r[8];
    win_shift[8] = in_gray_r;
  end

  assign win_eval = is_pix ? win_shift : win_r;

  spe_grad u_grad (
    .win         (win_eval),
    .kernel_mode (mode_r),
    .thr_sq      (thr_sq),
    .is_edge     (grad_edge)
  );

  assign oc_last   = (WW'(oc_r) == (w_eff - WW'(1)));
  assign orow_last = (orow_r == (h_eff - HW'(1)));
  assign interior  = (oc_r != '0) && ((WW'(oc_r) + WW'(2)) <= w_eff) &&
                     (orow_r != '0) && (({1'b0, orow_r} + (HW+1)'(2)) <= {1'b0, h_eff});

  always_comb begin
    if (is_pix) begin
      border_g = oc_last ? up_b : win_r[5];
    end else begin
      border_g = orow_last ? lo_b : up_b;
    end
  end

  assign edge_bit = interior ? grad_edge : (border_g >= thr_r);

  // ---------------- counters ----------------
  assign ic_inc   = WW'(ic_r) + WW'(1);
  assign owed_inc = owed_r + WW'(1);
  assign emit     = is_pix ? (owed_inc > (w_eff + WW'(1))) : (owed_r != '0);

  always_comb begin
    ic_nxt   = ic_r;
    oc_nxt   = oc_r;
    orow_nxt = orow_r;
    owed_nxt = owed_r;
    win_nxt  = win_r;
    if (geom_we) begin
      ic_nxt   = '0;
      oc_nxt   = '0;
      orow_nxt = '0;
      owed_nxt = '0;
    end else if (fire) begin
      if (is_pix) begin
        win_nxt  = win_shift;
        ic_nxt   = (ic_inc >= w_eff) ? '0 : ic_inc[COL_W-1:0];
        owed_nxt = emit ? owed_r : owed_inc;
      end else if (emit) begin
        owed_nxt = owed_r - WW'(1);
      end
      if (emit) begin
        if ((WW'(oc_r) + WW'(1)) >= w_eff) begin
          oc_nxt   = '0;
          orow_nxt = (({1'b0, orow_r} + (HW+1)'(1)) >= {1'b0, h_eff}) ? '0 :
                     orow_r + HW'(1);
        end else begin
          oc_nxt = oc_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r   <= '0;
      oc_r   <= '0;
      orow_r <= '0;
      owed_r <= '0;
      win_r  <= '0;
    end else begin
      ic_r   <= ic_nxt;
      oc_r   <= oc_nxt;
      orow_r <= orow_nxt;
      owed_r <= owed_nxt;
      win_r  <= win_nxt;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire && emit) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_data_r.edge_res     <= edge_bit;
      out_data_r.end_of_frame <= oc_last && orow_last;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

[tb/tb_sobel_prewitt_edge_binarize.sv]
`timescale 1ns / 100ps

class edge_tracker;
  logic [spe_pkg::WIDTH_W-1:0]  width_q;
  logic [spe_pkg::HEIGHT_W-1:0] height_q;
  logic                         kernel_q;
  logic [spe_pkg::THRESH_W-1:0] thresh_q;

  spe_pkg::pix_t upper [spe_pkg::MAX_WIDTH_DEF];
  spe_pkg::pix_t lower [spe_pkg::MAX_WIDTH_DEF];
  // entry holds a gray value written since reset
  bit   upper_ok [spe_pkg::MAX_WIDTH_DEF];
  bit   lower_ok [spe_pkg::MAX_WIDTH_DEF];
  spe_pkg::win_t win;
  bit [8:0] win_ok;

  int unsigned        in_col, in_row, out_col, out_row;
  spe_pkg::out_item_t edges_due[$];
  int unsigned        mismatches;

  function new();
    width_q    = spe_pkg::WIDTH_RST;
    height_q   = spe_pkg::HEIGHT_RST;
    kernel_q   = spe_pkg::KERNEL_SOBEL;
    thresh_q   = spe_pkg::THRESH_RST;
    win        = '0;
    win_ok     = '1;
    in_col     = 0;
    in_row     = 0;
    out_col    = 0;
    out_row    = 0;
    mismatches = 0;
  endfunction

  function int unsigned cols();
    int unsigned w;
    w = width_q;
    if (w < 3) w = 3;
    if (w > spe_pkg::MAX_WIDTH_DEF) w = spe_pkg::MAX_WIDTH_DEF;
    return w;
  endfunction

  function int unsigned rows();
    return (height_q < 3) ? 3 : height_q;
  endfunction

  // results the block still owes, in raster distance
  function int unsigned owed();
    int unsigned w, total;
    w = cols();
    total = w * rows();
    return (in_row * w + in_col + total - (out_row * w + out_col)) % total;
  endfunction

  function bit at_interior();
    return out_col >= 1 && out_col + 2 <= cols() && out_row >= 1 && out_row + 2 <= rows();
  endfunction

  function bit window_edge();
    int c, gx, gy;
    c  = (kernel_q == spe_pkg::KERNEL_PREWITT) ? 1 : 2;
    gx = (int'(win[2]) + c * int'(win[5]) + int'(win[8]))
       - (int'(win[0]) + c * int'(win[3]) + int'(win[6]));
    gy = (int'(win[0]) + c * int'(win[1]) + int'(win[2]))
       - (int'(win[6]) + c * int'(win[7]) + int'(win[8]));
    return (gx * gx + gy * gy) >= int'(thresh_q) * int'(thresh_q);
  endfunction

  function void emit(bit e);
    spe_pkg::out_item_t r;
    r.edge_res     = e;
    r.end_of_frame = (out_col == cols() - 1) && (out_row == rows() - 1);
    edges_due.push_back(r);
    out_col++;
    if (out_col >= cols()) begin
      out_col = 0;
      out_row++;
      if (out_row >= rows()) out_row = 0;
    end
  endfunction

  // a flush now would not read a store entry that was never written
  function bit flush_safe();
    if (owed() == 0) return 1'b1;
    if (at_interior()) return &win_ok;
    return (out_row == rows() - 1) ? lower_ok[out_col] : upper_ok[out_col];
  endfunction

  function void write_reg(spe_pkg::cfg_reg_t idx, logic [spe_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      spe_pkg::REG_IMAGE_WIDTH, spe_pkg::REG_IMAGE_HEIGHT: begin
        if (idx == spe_pkg::REG_IMAGE_WIDTH) width_q = v[spe_pkg::WIDTH_W-1:0];
        else height_q = v[spe_pkg::HEIGHT_W-1:0];
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
      end
      spe_pkg::REG_KERNEL_MODE: kernel_q = v[0];
      spe_pkg::REG_THRESHOLD:   thresh_q = v[spe_pkg::THRESH_W-1:0];
      default: ;
    endcase
  endfunction

  function void take_item(spe_pkg::in_item_t it);
    int unsigned   w, h, oc, orow, sum, k;
    bit            inner, e, top_ok, mid_ok;
    spe_pkg::pix_t g, top, mid;
    w     = cols();
    h     = rows();
    oc    = out_col;
    orow  = out_row;
    inner = at_interior();
    if (it.opcode == spe_pkg::OPC_FLUSH) begin
      if (owed() == 0) return;
      if (inner) e = window_edge();
      else begin
        g = (orow == h - 1) ? lower[oc] : upper[oc];
        e = g >= thresh_q;
      end
      emit(e);
      return;
    end
    sum    = int'(it.red) + int'(it.green) + int'(it.blue);
    g      = spe_pkg::pix_t'(sum / 3);
    top    = upper[in_col];
    mid    = lower[in_col];
    top_ok = upper_ok[in_col];
    mid_ok = lower_ok[in_col];
    for (k = 0; k < 3; k++) begin
      win[k*3]      = win[k*3+1];
      win[k*3+1]    = win[k*3+2];
      win_ok[k*3]   = win_ok[k*3+1];
      win_ok[k*3+1] = win_ok[k*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = g;
    win_ok[2] = top_ok;
    win_ok[5] = mid_ok;
    win_ok[8] = 1'b1;
    upper[in_col]    = mid;
    upper_ok[in_col] = mid_ok;
    lower[in_col]    = g;
    lower_ok[in_col] = 1'b1;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
      if (in_row >= h) in_row = 0;
    end
    if (owed() <= w + 1) return;
    if (inner) e = window_edge();
    else begin
      // last column has already left the window: take it from the upper line
      g = (oc == w - 1) ? upper[oc] : win[4];
      e = g >= thresh_q;
    end
    emit(e);
  endfunction

  function void check_edge(spe_pkg::out_item_t got);
    spe_pkg::out_item_t want;
    if (edges_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: edge_res=%0b end_of_frame=%0b",
                 got.edge_res, got.end_of_frame);
      return;
    end
    want = edges_due.pop_front();
    if (got.edge_res !== want.edge_res || got.end_of_frame !== want.end_of_frame) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected edge_res=%0b end_of_frame=%0b, got %0b %0b",
                 want.edge_res, want.end_of_frame, got.edge_res, got.end_of_frame);
    end
  endfunction
endclass

module tb_sobel_prewitt_edge_binarize;

  localparam int unsigned    RANDOM_ITEMS  = 1900;
  localparam int unsigned    HOLD_CYCLES   = 300;
  localparam int unsigned    SETTLE_CYCLES = 8;
  localparam int unsigned    CYCLE_LIMIT   = 3_000_000;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  spe_pkg::in_item_t              in_data;
  logic                           out_valid;
  logic                           out_stall;
  spe_pkg::out_item_t             out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [spe_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [spe_pkg::CFG_DATA_W-1:0] cfg_data;

  edge_tracker tracker = new();
  bit          valid_up = 1'b0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned cycle_count = 0;

  sobel_prewitt_edge_binarize uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_edge(out_data);
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side
  initial begin
    int unsigned n;
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = calm ? 0 : gap_len();
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic drop_valid();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic offer(input spe_pkg::in_item_t it);
    int unsigned n;
    in_valid <= 1'b1;
    in_data  <= it;
    valid_up = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_item(it);
    n = calm ? 0 : gap_len();
    if (n != 0) begin
      drop_valid();
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic offer_flush();
    spe_pkg::in_item_t it;
    it.opcode = spe_pkg::OPC_FLUSH;
    it.red    = $urandom_range(0, 255);
    it.green  = $urandom_range(0, 255);
    it.blue   = $urandom_range(0, 255);
    offer(it);
  endtask

  function automatic spe_pkg::in_item_t rand_pixel();
    spe_pkg::in_item_t it;
    it.opcode = spe_pkg::OPC_PIXEL;
    it.red    = $urandom_range(0, 255);
    it.green  = $urandom_range(0, 255);
    it.blue   = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0: {it.red, it.green, it.blue} = '0;
      1: {it.red, it.green, it.blue} = '1;
      2: begin
        it.green = it.red;
        it.blue  = it.red;
      end
      default: ;
    endcase
    return it;
  endfunction

  // flush out owed results as far as the line stores hold written data
  task automatic drain(inout int unsigned cnt);
    while (tracker.owed() != 0 && tracker.flush_safe()) begin
      offer_flush();
      cnt++;
    end
  endtask

  task automatic settle();
    drop_valid();
    while (tracker.edges_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input spe_pkg::cfg_reg_t idx,
                           input logic [spe_pkg::CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, v);
  endtask

  task automatic load_setup(input logic [spe_pkg::CFG_DATA_W-1:0] w_reg,
                            input logic [spe_pkg::CFG_DATA_W-1:0] h_reg,
                            input logic mode, input logic [spe_pkg::THRESH_W-1:0] thr);
    write_reg(spe_pkg::REG_IMAGE_WIDTH, w_reg);
    write_reg(spe_pkg::REG_IMAGE_HEIGHT, h_reg);
    write_reg(spe_pkg::REG_KERNEL_MODE, spe_pkg::CFG_DATA_W'(mode));
    write_reg(spe_pkg::REG_THRESHOLD, spe_pkg::CFG_DATA_W'(thr));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [23:0]                    rgb_set [9];
    spe_pkg::in_item_t              it;
    int unsigned                    k, f, p, n, w, h, frames, spent;
    bit                             big_done, hold_done;
    logic [spe_pkg::CFG_DATA_W-1:0] w_reg, h_reg;
    logic [spe_pkg::THRESH_W-1:0]   thr;
    logic                           mode;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= spe_pkg::REG_IMAGE_WIDTH;
    cfg_data  <= '0;
    spent     = 0;
    big_done  = 1'b0;
    hold_done = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3 frame from clamped geometry: colour extremes, one interior pixel, full drain
    load_setup('0, 12'd1, spe_pkg::KERNEL_SOBEL, 8'd100);
    rgb_set = '{24'h000000, 24'hFFFFFF, 24'hFFFFFF,
                24'h000000, 24'hFFFFFF, 24'h804020,
                24'hFF0000, 24'h00FF00, 24'h0000FF};
    for (k = 0; k < 9; k++) begin
      it.opcode = spe_pkg::OPC_PIXEL;
      {it.red, it.green, it.blue} = rgb_set[k];
      offer(it);
    end
    drain(spent);
    offer_flush();
    settle();

    // Prewitt at top threshold, flushed part way into the next frame
    write_reg(spe_pkg::REG_KERNEL_MODE, spe_pkg::CFG_DATA_W'(spe_pkg::KERNEL_PREWITT));
    write_reg(spe_pkg::REG_THRESHOLD, spe_pkg::CFG_DATA_W'(8'd255));
    cfg_valid <= 1'b0;
    for (k = 0; k < 3; k++) begin
      it.opcode = spe_pkg::OPC_PIXEL;
      {it.red, it.green, it.blue} = (k == 1) ? 24'h000000 : 24'hFFFFFF;
      offer(it);
    end
    drain(spent);
    offer_flush();
    settle();

    while (spent < RANDOM_ITEMS) begin
      if (!big_done && spent > 600) begin
        w_reg    = $urandom_range(0, 1) ? 12'd2047 : 12'd1024;
        h_reg    = $urandom_range(0, 3);
        big_done = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            w_reg = $urandom_range(0, 2);
            h_reg = $urandom_range(3, 5);
          end
          1: begin
            w_reg = $urandom_range(3, 6);
            h_reg = $urandom_range(0, 1) ? 12'd4095 : 12'($urandom_range(0, 2));
          end
          default: begin
            w_reg = $urandom_range(3, 10);
            h_reg = $urandom_range(3, 6);
          end
        endcase
      end
      mode = $urandom_range(0, 1);
      case ($urandom_range(0, 5))
        0:       thr = '0;
        1:       thr = '1;
        default: thr = $urandom_range(0, 255);
      endcase
      calm = ($urandom_range(0, 4) == 0);
      load_setup(w_reg, h_reg, mode, thr);
      w = tracker.cols();
      h = tracker.rows();

      if (w * h > 400) begin
        // too big for whole frames: a few rows, then drain what the stores allow
        n = (w > 64) ? w + $urandom_range(2, 40) : $urandom_range(w + 2, 5 * w + 20);
        for (k = 0; k < n; k++) begin
          offer(rand_pixel());
          spent++;
        end
        drain(spent);
      end else begin
        frames = $urandom_range(1, 3);
        for (f = 0; f < frames; f++) begin
          for (p = 0; p < w * h; p++) begin
            if ($urandom_range(0, 99) < 5 && tracker.flush_safe()) begin
              offer_flush();
              spent++;
            end
            offer(rand_pixel());
            spent++;
            if (!hold_done && spent >= 150) begin
              hold_req  = 1'b1;
              hold_done = 1'b1;
            end
            if ($urandom_range(0, 99) < 2) break;
          end
          // sometimes run straight into the next frame without draining
          if ($urandom_range(0, 9) < 7) begin
            drain(spent);
            if ($urandom_range(0, 3) == 0) offer_flush();
          end
        end
      end
      settle();
    end

    calm = 1'b0;
    settle();
    if (tracker.mismatches == 0 && tracker.edges_due.size() == 0)
      $display("tb_sobel_prewitt_edge_binarize: clean");
    else
      $display("tb_sobel_prewitt_edge_binarize: errors");
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("tb_sobel_prewitt_edge_binarize: errors");
    $finish;
  end

endmodule

[sobel_prewitt_edge_binarize.f]
src/spe_pkg.sv
src/spe_line_mem.sv
src/spe_grad.sv
src/sobel_prewitt_edge_binarize.sv
tb/tb_sobel_prewitt_edge_binarize.sv
